>>> rtl/dwpw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dwpw_pkg;

  localparam int PANEL_WIDTH  = 480;
  localparam int PANEL_HEIGHT = 320;

  localparam int COORD_W = 9;
  localparam int ADDR_W  = 18;
  localparam int PIXEL_W = 16;
  localparam int BYTE_W  = 8;
  localparam int NUM_PARAMS = 4;
  localparam int CNT_W   = 3;

  localparam logic [BYTE_W-1:0] CMD_COL_SET   = 8'h2A;
  localparam logic [BYTE_W-1:0] CMD_ROW_SET   = 8'h2B;
  localparam logic [BYTE_W-1:0] CMD_MEM_WRITE = 8'h2C;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EXEC = 1'b1;
  localparam logic DC_CMD    = 1'b0;
  localparam logic DC_DATA   = 1'b1;

  typedef struct packed {
    logic              kind;
    logic              dc_level;
    logic [BYTE_W-1:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic               pixel_valid;
    logic [ADDR_W-1:0]  pixel_address;
    logic [PIXEL_W-1:0] pixel_value;
    logic               frame_ready;
  } out_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] col_min;
    logic [COORD_W-1:0] col_max;
    logic [COORD_W-1:0] row_min;
    logic [COORD_W-1:0] row_max;
  } window_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } cursor_t;

endpackage

`default_nettype wire

>>> rtl/dwpw_cursor_advance.sv
`timescale 1ns / 1ps
`default_nettype none

module dwpw_cursor_advance
  import dwpw_pkg::*;
(
  input  wire window_t      win_i,
  input  wire cursor_t      cur_i,
  output cursor_t           cur_o,
  output logic              frame_hit_o,
  output logic [ADDR_W-1:0] addr_o
);

  logic [COORD_W-1:0] col_n;
  logic [COORD_W-1:0] row_n;
  logic [ADDR_W-1:0]  row_base;

  always_comb begin
    if (cur_i.col >= win_i.col_max) begin
      col_n = win_i.col_min;
      row_n = cur_i.row + COORD_W'(1);
    end else begin
      col_n = cur_i.col + COORD_W'(1);
      row_n = cur_i.row;
    end
  end

  assign frame_hit_o = (row_n >= win_i.row_max) && (col_n >= win_i.col_max);

  assign cur_o.col = col_n;
  assign cur_o.row = ({1'b0, row_n} >= (COORD_W+1)'(PANEL_HEIGHT)) ? win_i.row_min : row_n;

  assign row_base = {{(ADDR_W-COORD_W){1'b0}}, cur_i.row} * ADDR_W'(PANEL_WIDTH);
  assign addr_o   = row_base + {{(ADDR_W-COORD_W){1'b0}}, cur_i.col};

endmodule

`default_nettype wire

>>> rtl/display_window_pixel_writer_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Serial byte front end of a display controller. Each input transaction is
// either a received byte (command when dc_level is low, data when high) or an
// execute request that applies a pending column-set or row-set command. Under
// the memory-write command every second data byte completes an RGB565 pixel,
// which is reported with its frame memory address, and the cursor then
// advances (columns wrap in the window, rows after the panel's last row). Every
// input transaction yields exactly one output transaction. The block takes
// one transaction per clock cycle: all state is updated in the accepting
// cycle and the result is held in a single output register, so the input is
// stalled only while that register is full and the output side is stalling.

module display_window_pixel_writer_core
  import dwpw_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  localparam logic [COORD_W-1:0] COL_LIM = COORD_W'(PANEL_WIDTH - 1);
  localparam logic [COORD_W-1:0] ROW_LIM = COORD_W'(PANEL_HEIGHT - 1);

  logic [BYTE_W-1:0]  cmd_r,   cmd_nxt;
  logic [BYTE_W-1:0]  pb_r   [NUM_PARAMS];
  logic [BYTE_W-1:0]  pb_nxt [NUM_PARAMS];
  logic [CNT_W-1:0]   cnt_r,   cnt_nxt;
  window_t            win_r,   win_nxt;
  cursor_t            cur_r,   cur_nxt;
  logic               frame_r, frame_nxt;
  logic               out_valid_r;
  out_item_t          out_data_r, res_nxt;

  cursor_t            adv_cur;
  logic               adv_frame_hit;
  logic [ADDR_W-1:0]  adv_addr;
  logic               accept;
  logic [BYTE_W-1:0]  p0, p1, p2, p3;
  logic [2*BYTE_W-1:0] lo_val, hi_val;

  function automatic logic [COORD_W-1:0] clamp_coord(input logic [2*BYTE_W-1:0] v,
                                                      input logic [COORD_W-1:0] lim);
    logic [COORD_W-1:0] r;
    r = (v > {{(2*BYTE_W-COORD_W){1'b0}}, lim}) ? lim : v[COORD_W-1:0];
    return r;
  endfunction

  assign accept    = in_valid && !in_stall;
  assign in_stall  = out_valid_r && out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  dwpw_cursor_advance u_advance (
    .win_i       (win_r),
    .cur_i       (cur_r),
    .cur_o       (adv_cur),
    .frame_hit_o (adv_frame_hit),
    .addr_o      (adv_addr)
  );

  assign p0 = (cnt_r > CNT_W'(0)) ? pb_r[0] : '0;
  assign p1 = (cnt_r > CNT_W'(1)) ? pb_r[1] : '0;
  assign p2 = (cnt_r > CNT_W'(2)) ? pb_r[2] : '0;
  assign p3 = (cnt_r > CNT_W'(3)) ? pb_r[3] : '0;
  assign lo_val = {p0, p1};
  assign hi_val = {p2, p3};

  always_comb begin
    cmd_nxt   = cmd_r;
    pb_nxt    = pb_r;
    cnt_nxt   = cnt_r;
    win_nxt   = win_r;
    cur_nxt   = cur_r;
    frame_nxt = frame_r;
    res_nxt   = '0;
    if (accept) begin
      if (in_data.kind == KIND_EXEC) begin
        case (cmd_r)
          CMD_COL_SET: begin
            win_nxt.col_min = clamp_coord(lo_val, COL_LIM);
            win_nxt.col_max = clamp_coord(hi_val, COL_LIM);
            cur_nxt.col     = clamp_coord(lo_val, COL_LIM);
          end
          CMD_ROW_SET: begin
            win_nxt.row_min = clamp_coord(lo_val, ROW_LIM);
            win_nxt.row_max = clamp_coord(hi_val, ROW_LIM);
            cur_nxt.row     = clamp_coord(lo_val, ROW_LIM);
          end
          default: begin
          end
        endcase
        for (int i = 0; i < NUM_PARAMS; i++) begin
          pb_nxt[i] = '0;
        end
        cnt_nxt = '0;
      end else if (in_data.dc_level == DC_CMD) begin
        cmd_nxt = in_data.byte_value;
      end else begin
        if (cnt_r < CNT_W'(NUM_PARAMS)) begin
          pb_nxt[cnt_r[1:0]] = in_data.byte_value;
          cnt_nxt            = cnt_r + CNT_W'(1);
        end
        if ((cmd_r == CMD_MEM_WRITE) && (cnt_nxt == CNT_W'(2))) begin
          res_nxt.pixel_valid   = 1'b1;
          res_nxt.pixel_address = adv_addr;
          res_nxt.pixel_value   = {pb_nxt[0], pb_nxt[1]};
          cur_nxt               = adv_cur;
          if (adv_frame_hit) begin
            frame_nxt = 1'b1;
          end
          for (int i = 0; i < NUM_PARAMS; i++) begin
            pb_nxt[i] = '0;
          end
          cnt_nxt = '0;
        end
      end
    end
    res_nxt.frame_ready = frame_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r   <= '0;
      cnt_r   <= '0;
      win_r   <= '0;
      cur_r   <= '0;
      frame_r <= 1'b0;
      for (int i = 0; i < NUM_PARAMS; i++) begin
        pb_r[i] <= '0;
      end
    end else begin
      cmd_r   <= cmd_nxt;
      cnt_r   <= cnt_nxt;
      win_r   <= win_nxt;
      cur_r   <= cur_nxt;
      frame_r <= frame_nxt;
      pb_r    <= pb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= res_nxt;
    end
  end

  // The frame flag is only ever cleared by reset.
  assert property (@(posedge clk) disable iff (!rst_n) frame_r |=> frame_r)
    else $error("frame flag cleared outside reset");

  // Window limits and cursor always lie on the panel.
  assert property (@(posedge clk) disable iff (!rst_n)
      ({1'b0, win_r.col_max} < (COORD_W+1)'(PANEL_WIDTH)) &&
      ({1'b0, win_r.row_max} < (COORD_W+1)'(PANEL_HEIGHT)) &&
      ({1'b0, cur_r.col} < (COORD_W+1)'(PANEL_WIDTH)) &&
      ({1'b0, cur_r.row} < (COORD_W+1)'(PANEL_HEIGHT)))
    else $error("window or cursor outside the panel");

  // The parameter count never passes the number of parameter bytes.
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= CNT_W'(NUM_PARAMS))
    else $error("parameter count overflow");

  // A result without a pixel carries a zero address and value.
  assert property (@(posedge clk) disable iff (!rst_n)
      (out_valid_r && !out_data_r.pixel_valid) |->
      (out_data_r.pixel_address == '0) && (out_data_r.pixel_value == '0))
    else $error("pixel fields set without a pixel");

  // Completing a pixel empties the parameter store.
  assert property (@(posedge clk) disable iff (!rst_n)
      (accept && (in_data.kind == KIND_BYTE) && (in_data.dc_level == DC_DATA) &&
       (cmd_r == CMD_MEM_WRITE) && (cnt_r == CNT_W'(1)))
      |=> (cnt_r == '0) && out_data_r.pixel_valid)
    else $error("pixel transaction did not clear parameters");

endmodule

`default_nettype wire
